/* src/ppd_pkg.sv */
`default_nettype none

package ppd_pkg;

  // pattern table geometry
  localparam int MAX_PATTERNS = 4;
  localparam int PAT_IDX_W    = $clog2(MAX_PATTERNS);
  localparam int PAT_CNT_W    = $clog2(MAX_PATTERNS + 1);

  // clock pulses must stay below this bound to start a sync
  localparam int CLOCK_LIMIT  = 3276;

  // divide by ten: multiply by ceil(2^19 / 10), exact for inputs below 2^18
  localparam logic [15:0] RECIP_TEN   = 16'd52429;
  localparam int          RECIP_SHIFT = 19;

  localparam logic [11:0] TOL_MAX   = 12'hFFF;
  localparam logic [7:0]  MSG_MAX   = 8'hFF;
  localparam logic [15:0] ROUND_ADD = 16'd5;

  // configuration register reset values
  localparam logic [3:0] SYNC_MIN_FACTOR_RST  = 4'd10;
  localparam logic [3:0] TOL_TENTHS_RST       = 4'd4;
  localparam logic [7:0] MIN_MESSAGE_LEN_RST  = 8'd8;

  typedef enum logic [1:0] {
    CFG_SYNC_MIN_FACTOR = 2'd0,
    CFG_TOL_TENTHS      = 2'd1,
    CFG_MIN_MSG_LEN     = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    KIND_SYMBOL  = 2'd0,
    KIND_SUMMARY = 2'd1,
    KIND_ENTRY   = 2'd2
  } result_kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_SCAN,
    S_DECIDE,
    S_SYMBOL,
    S_SUMMARY,
    S_ENTRY,
    S_CLEAR,
    S_SYNC,
    S_TOL
  } state_t;

  typedef struct packed {
    logic signed [15:0] high;
    logic signed [15:0] low;
  } entry_t;

  typedef struct packed {
    logic pair_ok;
    logic sync_hit;
  } pair_status_t;

  // |a - b| < tol on sign-extended pulse values
  function automatic logic within_tol(input logic signed [17:0] a,
                                      input logic signed [17:0] b,
                                      input logic [11:0] tol);
    logic signed [17:0] d;
    logic [17:0] mag;
    d   = a - b;
    mag = d[17] ? 18'(-d) : 18'(d);
    return mag < {6'd0, tol};
  endfunction

  function automatic logic signed [17:0] sext18(input logic signed [15:0] v);
    return $signed({{2{v[15]}}, v});
  endfunction

endpackage

`default_nettype wire

/* src/ppd_timing.sv */
`default_nettype none

module ppd_timing (
  input  wire                   clk,
  input  wire logic signed [15:0] first,
  input  wire logic signed [15:0] cur,
  input  wire logic [3:0]       smf,
  input  wire logic [3:0]       tenths,
  input  wire logic [11:0]      clock_length,
  input  wire logic [11:0]      tolerance,
  output ppd_pkg::pair_status_t status,
  output logic [11:0]           tol_new
);

  logic signed [17:0] first_x;
  logic signed [17:0] cur_x;
  logic signed [17:0] neg_cur;
  logic signed [17:0] clk_x;
  logic signed [17:0] neg_clk;
  logic [15:0]        smf_clk;
  logic signed [17:0] smf_clk_x;
  logic [18:0]        smf_first;
  logic               first_pos;
  logic               cond_a;
  logic               cond_b;
  logic [15:0]        tol_prod;
  logic [31:0]        tol_scaled;
  logic [12:0]        tol_quot;

  always_comb begin
    first_x   = ppd_pkg::sext18(first);
    cur_x     = ppd_pkg::sext18(cur);
    neg_cur   = -cur_x;
    clk_x     = $signed({6'd0, clock_length});
    neg_clk   = -clk_x;
    smf_clk   = {12'd0, smf} * {4'd0, clock_length};
    smf_clk_x = $signed({2'b00, smf_clk});
    smf_first = {4'd0, first[14:0]} * {15'd0, smf};
    first_pos = !first[15] && (first != 16'sd0);

    cond_a = ppd_pkg::within_tol(first_x, clk_x, tolerance) &&
             (smf_clk_x > neg_cur) && cur[15];
    cond_b = first_pos && (first_x < smf_clk_x) &&
             ppd_pkg::within_tol(cur_x, neg_clk, tolerance);

    status.pair_ok  = cond_a || cond_b;
    status.sync_hit = first_pos &&
                      (first_x < $signed(18'(ppd_pkg::CLOCK_LIMIT))) &&
                      ($signed({1'b0, smf_first}) <= $signed({{2{neg_cur[17]}}, neg_cur}));
  end

  // tolerance = round(clock * tenths / 10), product registered before the divide
  always_ff @(posedge clk) begin
    tol_prod <= 16'({4'd0, first[11:0]} * {12'd0, tenths}) + ppd_pkg::ROUND_ADD;
  end

  always_comb begin
    tol_scaled = {16'd0, tol_prod} * {16'd0, ppd_pkg::RECIP_TEN};
    tol_quot   = tol_scaled[31:ppd_pkg::RECIP_SHIFT];
    tol_new    = tol_quot[12] ? ppd_pkg::TOL_MAX : tol_quot[11:0];
  end

endmodule

`default_nettype wire

/* src/ppd_table.sv */
`default_nettype none

module ppd_table (
  input  wire                                  clk,
  input  wire                                  wr_en,
  input  wire logic [ppd_pkg::PAT_IDX_W-1:0]   wr_addr,
  input  wire ppd_pkg::entry_t                 wr_data,
  input  wire                                  rd_en,
  input  wire logic [ppd_pkg::PAT_IDX_W-1:0]   rd_addr,
  input  wire logic signed [15:0]              first,
  input  wire logic signed [15:0]              cur,
  input  wire logic [11:0]                     tolerance,
  output ppd_pkg::entry_t                      rd_data,
  output logic                                 hit
);

  ppd_pkg::entry_t mem [ppd_pkg::MAX_PATTERNS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // pair against the entry just read
  assign hit = ppd_pkg::within_tol(ppd_pkg::sext18(first),
                                   ppd_pkg::sext18(rd_data.high), tolerance) &&
               ppd_pkg::within_tol(ppd_pkg::sext18(cur),
                                   ppd_pkg::sext18(rd_data.low), tolerance);

endmodule

`default_nettype wire

/* src/pulse_pattern_detector_core.sv */
`default_nettype none

// channel   dir  handshake             payload
// in        in   in_valid / in_stall   pulse_duration
// out       out  out_valid / out_stall result_kind .. last_of_run (one port per field)
// cfg       in   cfg_write             cfg_index, cfg_data
//
// one pulse at a time: an unpaired pulse goes to the sync check; a valid pair is scanned
// against the stored patterns into a symbol; an invalid pair or a full table with no match
// gives a summary, entry beats and a clear; a sync adds a tolerance step; one table read
// a cycle unless out_stall holds the sequencer; rst is synchronous and clears all control
// state; the table is not cleared, only entries below the pattern count are ever read
// out_stall holds the output register and the sequencer, the last beat may wait on the next

module pulse_pattern_detector_core (
  input  wire                 clk,
  input  wire                 rst,

  input  wire                 in_valid,
  output logic                in_stall,
  input  wire logic signed [15:0] pulse_duration,

  output logic                out_valid,
  input  wire                 out_stall,
  output logic [1:0]          result_kind,
  output logic [1:0]          symbol_index,
  output logic [7:0]          message_length,
  output logic [2:0]          patterns_used,
  output logic [11:0]         clock_value,
  output logic signed [15:0]  sync_value,
  output logic signed [15:0]  entry_high,
  output logic signed [15:0]  entry_low,
  output logic                long_enough,
  output logic                last_of_run,

  input  wire                 cfg_write,
  input  wire logic [1:0]     cfg_index,
  input  wire logic [7:0]     cfg_data
);

  localparam int IW = ppd_pkg::PAT_IDX_W;
  localparam int CW = ppd_pkg::PAT_CNT_W;

  ppd_pkg::state_t state;
  ppd_pkg::state_t state_next;

  // configuration
  logic [3:0] sync_min_factor;
  logic [3:0] tolerance_tenths;
  logic [7:0] min_message_len;

  // detector state
  logic signed [15:0] prev_pulse;
  logic signed [15:0] first_pulse;
  logic signed [15:0] cur_pulse;
  logic               detecting;
  logic               pair_phase;
  logic [11:0]        clock_length;
  logic signed [15:0] sync_length;
  logic [11:0]        tolerance;
  logic [CW-1:0]      pattern_count;
  logic [7:0]         message_count;

  // table walk
  logic [IW-1:0]      scan_idx;
  logic               found_hit;
  logic [IW-1:0]      found_idx;
  logic               scan_more;
  logic               table_room;
  logic               msg_long;

  // table port
  logic               rd_en;
  logic [IW-1:0]      rd_addr;
  logic               wr_en;
  ppd_pkg::entry_t    wr_data;
  ppd_pkg::entry_t    rd_data;
  logic               tbl_hit;

  ppd_pkg::pair_status_t status;
  logic [11:0]        tol_new;

  // output register load
  logic               can_load;
  logic               out_load;
  logic [1:0]         kind_next;
  logic [IW-1:0]      index_next;
  logic signed [15:0] high_next;
  logic signed [15:0] low_next;
  logic               last_next;

  ppd_timing u_timing (
    .clk          (clk),
    .first        (first_pulse),
    .cur          (cur_pulse),
    .smf          (sync_min_factor),
    .tenths       (tolerance_tenths),
    .clock_length (clock_length),
    .tolerance    (tolerance),
    .status       (status),
    .tol_new      (tol_new)
  );

  assign wr_data.high = first_pulse;
  assign wr_data.low  = cur_pulse;

  ppd_table u_table (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (pattern_count[IW-1:0]),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .first     (first_pulse),
    .cur       (cur_pulse),
    .tolerance (tolerance),
    .rd_data   (rd_data),
    .hit       (tbl_hit)
  );

  assign scan_more  = ({1'b0, scan_idx} + CW'(1)) < pattern_count;
  assign table_room = pattern_count < CW'(ppd_pkg::MAX_PATTERNS);
  assign msg_long   = message_count >= min_message_len;
  assign can_load   = !out_valid || !out_stall;
  assign in_stall   = (state != ppd_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: next state, table port and output beat selection
  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    out_load   = 1'b0;
    kind_next  = ppd_pkg::KIND_SYMBOL;
    index_next = '0;
    high_next  = '0;
    low_next   = '0;
    last_next  = 1'b1;
    unique case (state)
      ppd_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = ppd_pkg::S_EVAL;
        end
      end
      ppd_pkg::S_EVAL: begin
        if (detecting && pair_phase) begin
          if (!status.pair_ok) begin
            state_next = ppd_pkg::S_SUMMARY;
          end else if (pattern_count == '0) begin
            state_next = ppd_pkg::S_DECIDE;
          end else begin
            rd_en      = 1'b1;
            state_next = ppd_pkg::S_SCAN;
          end
        end else begin
          state_next = ppd_pkg::S_SYNC;
        end
      end
      ppd_pkg::S_SCAN: begin
        if (scan_more) begin
          rd_en   = 1'b1;
          rd_addr = scan_idx + IW'(1);
        end else begin
          state_next = ppd_pkg::S_DECIDE;
        end
      end
      ppd_pkg::S_DECIDE: begin
        if (found_hit) begin
          state_next = ppd_pkg::S_SYMBOL;
        end else if (table_room) begin
          wr_en      = 1'b1;
          state_next = ppd_pkg::S_SYMBOL;
        end else begin
          state_next = ppd_pkg::S_SUMMARY;
        end
      end
      ppd_pkg::S_SYMBOL: begin
        index_next = found_idx;
        if (can_load) begin
          out_load   = 1'b1;
          state_next = ppd_pkg::S_SYNC;
        end
      end
      ppd_pkg::S_SUMMARY: begin
        kind_next = ppd_pkg::KIND_SUMMARY;
        last_next = !(msg_long && (pattern_count != '0));
        if (can_load) begin
          out_load = 1'b1;
          if (msg_long && (pattern_count != '0)) begin
            rd_en      = 1'b1;
            state_next = ppd_pkg::S_ENTRY;
          end else begin
            state_next = ppd_pkg::S_CLEAR;
          end
        end
      end
      ppd_pkg::S_ENTRY: begin
        kind_next  = ppd_pkg::KIND_ENTRY;
        index_next = scan_idx;
        high_next  = rd_data.high;
        low_next   = rd_data.low;
        last_next  = !scan_more;
        if (can_load) begin
          out_load = 1'b1;
          if (scan_more) begin
            rd_en   = 1'b1;
            rd_addr = scan_idx + IW'(1);
          end else begin
            state_next = ppd_pkg::S_CLEAR;
          end
        end
      end
      ppd_pkg::S_CLEAR: begin
        state_next = ppd_pkg::S_SYNC;
      end
      ppd_pkg::S_SYNC: begin
        state_next = status.sync_hit ? ppd_pkg::S_TOL : ppd_pkg::S_IDLE;
      end
      ppd_pkg::S_TOL: begin
        state_next = ppd_pkg::S_IDLE;
      end
      default: begin
        state_next = ppd_pkg::S_IDLE;
      end
    endcase
  end

  // pulse pair under work
  always_ff @(posedge clk) begin
    if (state == ppd_pkg::S_IDLE && in_valid) begin
      cur_pulse   <= pulse_duration;
      first_pulse <= prev_pulse;
    end
  end

  // configuration and detector state
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_min_factor  <= ppd_pkg::SYNC_MIN_FACTOR_RST;
      tolerance_tenths <= ppd_pkg::TOL_TENTHS_RST;
      min_message_len  <= ppd_pkg::MIN_MESSAGE_LEN_RST;
      prev_pulse       <= '0;
      detecting        <= 1'b0;
      pair_phase       <= 1'b0;
      clock_length     <= '0;
      sync_length      <= '0;
      tolerance        <= '0;
      pattern_count    <= '0;
      message_count    <= '0;
      scan_idx         <= '0;
      found_hit        <= 1'b0;
      found_idx        <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          ppd_pkg::CFG_SYNC_MIN_FACTOR: sync_min_factor  <= cfg_data[3:0];
          ppd_pkg::CFG_TOL_TENTHS:      tolerance_tenths <= cfg_data[3:0];
          ppd_pkg::CFG_MIN_MSG_LEN:     min_message_len  <= cfg_data;
          default: begin
          end
        endcase
      end
      unique case (state)
        ppd_pkg::S_IDLE: begin
          if (in_valid) begin
            prev_pulse <= pulse_duration;
          end
        end
        ppd_pkg::S_EVAL: begin
          if (detecting) begin
            pair_phase <= !pair_phase;
          end
          scan_idx  <= '0;
          found_hit <= 1'b0;
        end
        ppd_pkg::S_SCAN: begin
          // later hits override earlier ones
          if (tbl_hit) begin
            found_hit <= 1'b1;
            found_idx <= scan_idx;
          end
          if (scan_more) begin
            scan_idx <= scan_idx + IW'(1);
          end
        end
        ppd_pkg::S_DECIDE: begin
          if (!found_hit && table_room) begin
            found_idx     <= pattern_count[IW-1:0];
            pattern_count <= pattern_count + CW'(1);
          end
          if ((found_hit || table_room) && (message_count != ppd_pkg::MSG_MAX)) begin
            message_count <= message_count + 8'd1;
          end
        end
        ppd_pkg::S_SUMMARY: begin
          scan_idx <= '0;
        end
        ppd_pkg::S_ENTRY: begin
          if (can_load && scan_more) begin
            scan_idx <= scan_idx + IW'(1);
          end
        end
        ppd_pkg::S_CLEAR: begin
          message_count <= '0;
          pattern_count <= '0;
          pair_phase    <= 1'b0;
          detecting     <= 1'b0;
          clock_length  <= '0;
        end
        ppd_pkg::S_SYNC: begin
          if (status.sync_hit) begin
            clock_length <= first_pulse[11:0];
            sync_length  <= cur_pulse;
            detecting    <= 1'b1;
            pair_phase   <= 1'b0;
          end
        end
        ppd_pkg::S_TOL: begin
          tolerance <= tol_new;
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_kind    <= kind_next;
      symbol_index   <= index_next;
      message_length <= message_count;
      patterns_used  <= pattern_count;
      clock_value    <= clock_length;
      sync_value     <= sync_length;
      entry_high     <= high_next;
      entry_low      <= low_next;
      long_enough    <= msg_long;
      last_of_run    <= last_next;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    pattern_count <= CW'(ppd_pkg::MAX_PATTERNS))
    else $error("pattern count beyond table size");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !out_load)
    else $error("output register loaded while a beat waits");

  a_clock_set: assert property (@(posedge clk) disable iff (rst)
    detecting |-> (clock_length != '0))
    else $error("detecting without a measured clock");

  a_write_room: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (table_room && !found_hit))
    else $error("table write without a free entry");
`endif

endmodule

`default_nettype wire
